/* sv/dfc_pkg.sv */
// shared constants, types and crc function for the datagram frame checker
`default_nettype none

package dfc_pkg;

    localparam int MAX_FRAME_BYTES = 65536;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int HDR_BYTES       = 36;
    localparam int HDR_IDX_W       = $clog2(HDR_BYTES);

    localparam logic [31:0] FRAME_MAGIC   = 32'h3154_4E53;
    localparam logic [15:0] FRAME_VERSION = 16'd1;
    localparam logic [31:0] CRC32C_POLY   = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_CRC     = 3'd5
    } status_t;

    typedef struct packed {
        logic        is_payload;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [2:0]  status;
        logic [15:0] packet_kind;
        logic [31:0] stream_number;
        logic [63:0] sequence_number;
        logic [63:0] sender_node;
        logic [31:0] payload_length;
    } result_t;

    // reflected crc-32c, one byte, lsb first
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/dfc_result_buf.sv */
// two-entry output buffer: result register plus skid stage
`default_nettype none

module dfc_result_buf
    import dfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop          = out_valid_reg && !result_stall;
    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                out_reg <= push_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while result register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("item pushed while buffer is full");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall))
        else $error("skid stage loaded without a stalled result");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage did not move into result register");
`endif

endmodule

`default_nettype wire

/* sv/datagram_frame_check.sv */
// top level: datagram header parse, payload pass-through and crc-32c check
//
//  channel  | valid         | stall         | fields
//  ---------+---------------+---------------+------------------------------------------
//  byte in  | byte_valid    | byte_stall    | data_byte, last_byte
//  result   | result_valid  | result_stall  | is_payload, payload_byte, frame_end,
//           |               |               | status, packet_kind, stream_number,
//           |               |               | sequence_number, sender_node, payload_length
//
// one byte item per cycle while byte_stall is low; the edge that takes a payload
// or last byte writes its result into the result register (offered from the
// next cycle on) or, when that one is stalled, into the skid stage; header decode
// and one-byte crc-32c are a single pass of logic in front of both registers
// rst_n clears the byte count, crc and buffer state; header bytes need no reset
// byte_stall rises only when both the result register and the skid stage hold
// an item, so one stalled result never blocks the next byte
`default_nettype none

module datagram_frame_check
    import dfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             is_payload,
    output logic [7:0]       payload_byte,
    output logic             frame_end,
    output logic [2:0]       status,
    output logic [15:0]      packet_kind,
    output logic [31:0]      stream_number,
    output logic [63:0]      sequence_number,
    output logic [63:0]      sender_node,
    output logic [31:0]      payload_length
);

    // frame state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [7:0]       hdr_reg  [HDR_BYTES];
    logic [7:0]       hdr_next [HDR_BYTES];

    logic             take;
    logic             buf_full;
    logic             below_max;
    logic             in_header;
    logic             pay;
    logic [CNT_W-1:0] count_upd;
    logic [CNT_W-1:0] pay_offset;
    logic [31:0]      len_old;
    logic [31:0]      crc_upd;
    logic             hdr_done;
    status_t          verdict;
    result_t          res;
    result_t          res_out;

    // header field views, taken after the current byte is written
    logic [31:0]      f_magic;
    logic [15:0]      f_version;
    logic [15:0]      f_kind;
    logic [31:0]      f_stream;
    logic [63:0]      f_seq;
    logic [63:0]      f_node;
    logic [31:0]      f_len;
    logic [31:0]      f_crc;

    assign take       = byte_valid && !byte_stall;
    assign byte_stall = buf_full;

    // byte position and payload window
    assign below_max  = count_reg < CNT_W'(MAX_FRAME_BYTES);
    assign in_header  = count_reg < CNT_W'(HDR_BYTES);
    assign pay_offset = count_reg - CNT_W'(HDR_BYTES);
    assign len_old    = {hdr_reg[31], hdr_reg[30], hdr_reg[29], hdr_reg[28]};
    assign pay        = below_max && !in_header
                        && ({{(32 - CNT_W){1'b0}}, pay_offset} < len_old);
    assign count_upd  = below_max ? (count_reg + CNT_W'(1)) : count_reg;
    assign crc_upd    = pay ? crc32c_byte(crc_reg, data_byte) : crc_reg;
    assign hdr_done   = count_upd >= CNT_W'(HDR_BYTES);

    // drop the incoming byte into its header slot
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (in_header)
        begin
            hdr_next[count_reg[HDR_IDX_W-1:0]] = data_byte;
        end
    end

    assign f_magic   = {hdr_next[3], hdr_next[2], hdr_next[1], hdr_next[0]};
    assign f_version = {hdr_next[5], hdr_next[4]};
    assign f_kind    = {hdr_next[7], hdr_next[6]};
    assign f_stream  = {hdr_next[11], hdr_next[10], hdr_next[9], hdr_next[8]};
    assign f_seq     = {hdr_next[19], hdr_next[18], hdr_next[17], hdr_next[16],
                        hdr_next[15], hdr_next[14], hdr_next[13], hdr_next[12]};
    assign f_node    = {hdr_next[27], hdr_next[26], hdr_next[25], hdr_next[24],
                        hdr_next[23], hdr_next[22], hdr_next[21], hdr_next[20]};
    assign f_len     = {hdr_next[31], hdr_next[30], hdr_next[29], hdr_next[28]};
    assign f_crc     = {hdr_next[35], hdr_next[34], hdr_next[33], hdr_next[32]};

    // verdict, first failing check wins
    always_comb
    begin
        priority if (!hdr_done)
        begin
            verdict = ST_SHORT;
        end
        else if (f_magic != FRAME_MAGIC)
        begin
            verdict = ST_MAGIC;
        end
        else if (f_version != FRAME_VERSION)
        begin
            verdict = ST_VERSION;
        end
        else if ({{(33 - CNT_W){1'b0}}, count_upd} != (33'(HDR_BYTES) + {1'b0, f_len}))
        begin
            verdict = ST_LENGTH;
        end
        else if ((crc_upd ^ CRC_INIT) != f_crc)
        begin
            verdict = ST_CRC;
        end
        else
        begin
            verdict = ST_OK;
        end
    end

    always_comb
    begin
        res.is_payload      = pay;
        res.payload_byte    = pay ? data_byte : 8'd0;
        res.frame_end       = last_byte;
        res.status          = last_byte ? verdict : ST_OK;
        res.packet_kind     = hdr_done ? f_kind   : 16'd0;
        res.stream_number   = hdr_done ? f_stream : 32'd0;
        res.sequence_number = hdr_done ? f_seq    : 64'd0;
        res.sender_node     = hdr_done ? f_node   : 64'd0;
        res.payload_length  = hdr_done ? f_len    : 32'd0;
    end

    // last byte clears the frame for the next datagram
    assign count_next = last_byte ? '0 : count_upd;
    assign crc_next   = last_byte ? CRC_INIT : crc_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end
        else if (take)
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // header bytes are always rewritten before they are read again
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    dfc_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (take && (pay || last_byte)),
        .push_data    (res),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (res_out)
    );

    assign is_payload      = res_out.is_payload;
    assign payload_byte    = res_out.payload_byte;
    assign frame_end       = res_out.frame_end;
    assign status          = res_out.status;
    assign packet_kind     = res_out.packet_kind;
    assign stream_number   = res_out.stream_number;
    assign sequence_number = res_out.sequence_number;
    assign sender_node     = res_out.sender_node;
    assign payload_length  = res_out.payload_length;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME_BYTES))
        else $error("byte count passed its bound");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_byte) |=> (count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after last byte");

    a_no_payload_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        pay |-> (count_reg >= CNT_W'(HDR_BYTES)))
        else $error("payload flagged inside header");
`endif

endmodule

`default_nettype wire
